/* rtl/bitmap_find_first_and_mark_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap find-first unit
// Implication checks under the unit clock, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FIND_FIRST_AND_MARK_UNIT_ASSERT_SVH
`define BITMAP_FIND_FIRST_AND_MARK_UNIT_ASSERT_SVH

// same-cycle implication
`define BFFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bffm assertion failed");

// next-cycle implication
`define BFFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bffm assertion failed");

`endif

/* rtl/bffm_pkg.sv */
// ---------------------------------------------------------------------------
// bffm_pkg
// Widths, codes and defaults shared by the bitmap find-first unit.
// ---------------------------------------------------------------------------
package bffm_pkg;

    localparam int CNT_W     = 11;          // bit_count register
    localparam int IDX_W     = 10;          // target bit / position
    localparam int CNT_MAX   = 2**CNT_W - 1;
    localparam int CNT_RESET = 1024;

    localparam int MAX_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        CMD_FIND_SET   = 2'd0,
        CMD_FIND_CLEAR = 2'd1,
        CMD_SET_BIT    = 2'd2,
        CMD_CLEAR_BIT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage

/* rtl/bffm_ram.sv */
// ---------------------------------------------------------------------------
// bffm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module bffm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bitmap_find_first_and_mark_unit.sv */
// ---------------------------------------------------------------------------
// bitmap_find_first_and_mark_unit
// Bitmap held in a word RAM; finds the lowest set or clear bit below the
// configured bound, or sets / clears one bit, walking the RAM one word a cycle.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------
//  in       | to unit   | i_in_valid / o_in_stall    | i_command, i_target_bit
//  out      | from unit | o_out_valid / i_out_stall  | o_found, o_position
//  cfg      | to unit   | i_cfg_wr_en                | i_cfg_wr_data (bit_count)
//
//  A find stops at the word that holds its hit, and a miss walks every word
//  below the bound; set and clear walk up to the word that holds the target.
//  The RAM read port walks one word per cycle. A set or clear with an index
//  outside the bound skips the walk and goes straight to the result state.
//  After reset a clearing pass writes zeros over all MAX_BITS / WORD_BITS
//  words (rounded up), one per cycle, with the input stalled.
//  One word is worked on at a time; the input stalls until its result is
//  loaded into the output register, which then holds while i_out_stall is high.
// ---------------------------------------------------------------------------
`include "bitmap_find_first_and_mark_unit_assert.svh"

module bitmap_find_first_and_mark_unit #(
    parameter int MAX_BITS  = bffm_pkg::MAX_BITS_DEF,
    parameter int WORD_BITS = bffm_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bffm_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_command,
    input  logic [bffm_pkg::IDX_W-1:0] i_target_bit,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_found,
    output logic [bffm_pkg::IDX_W-1:0] o_position
);

    import bffm_pkg::*;

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int BASE_W    = $clog2(CNT_MAX + 1 + WORD_BITS);
    localparam int CAP_INT   = (MAX_BITS < CNT_MAX) ? MAX_BITS : CNT_MAX;
    localparam logic [CNT_W-1:0]  CAP       = CNT_W'(CAP_INT);
    localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [BASE_W-1:0] WORD_STEP = BASE_W'(WORD_BITS);

    // control
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_bit_count;
    logic                  r_ovalid, n_ovalid;
    logic                  r_pend, n_pend;

    // datapath
    t_cmd                  r_cmd, n_cmd;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_lim, n_lim;
    logic [AW-1:0]         r_addr, n_addr;
    logic [BASE_W-1:0]     r_base, n_base;
    logic [AW-1:0]         r_chk_addr, n_chk_addr;
    logic [BASE_W-1:0]     r_chk_base, n_chk_base;
    logic                  r_res_found, n_res_found;
    logic [IDX_W-1:0]      r_res_pos, n_res_pos;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_pos, n_pos;

    // ram port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;

    // word evaluation
    logic [CNT_W-1:0]      cur_lim;
    logic [BASE_W-1:0]     rem;
    logic [BASE_W-1:0]     sc_off;
    logic                  sc_hit;
    logic [WORD_BITS-1:0]  vmask;
    logic [WORD_BITS-1:0]  cand;
    logic [WORD_BITS-1:0]  bit_mask;
    logic                  ffs_hit;
    logic [BIT_W-1:0]      ffs_k;
    logic                  is_find;
    logic                  issue;
    logic                  in_acc;
    logic                  out_free;

    bffm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_rdata)
    );

    // word evaluation: lowest matching bit below the bound, or the target bit
    always_comb begin
        cur_lim  = (r_bit_count > CAP) ? CAP : r_bit_count;
        is_find  = (r_cmd == CMD_FIND_SET) || (r_cmd == CMD_FIND_CLEAR);
        rem      = BASE_W'(r_lim) - r_chk_base;
        sc_off   = BASE_W'(r_idx) - r_chk_base;
        sc_hit   = sc_off < WORD_STEP;
        bit_mask = WORD_BITS'(1) << sc_off[BIT_W-1:0];
        for (int k = 0; k < WORD_BITS; k++) begin
            vmask[k] = BASE_W'(k) < rem;
        end
        cand    = ((r_cmd == CMD_FIND_SET) ? ram_rdata : ~ram_rdata) & vmask;
        ffs_hit = 1'b0;
        ffs_k   = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (cand[k]) begin
                ffs_hit = 1'b1;
                ffs_k   = BIT_W'(k);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ovalid    = r_ovalid;
        n_pend      = r_pend;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_addr      = r_addr;
        n_base      = r_base;
        n_chk_addr  = r_chk_addr;
        n_chk_base  = r_chk_base;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_found     = r_found;
        n_pos       = r_pos;
        ram_we      = 1'b0;
        ram_waddr   = r_chk_addr;
        ram_wdata   = '0;
        issue       = 1'b0;

        out_free   = !r_ovalid || !i_out_stall;
        o_in_stall = (r_state != ST_IDLE);
        in_acc     = i_in_valid && (r_state == ST_IDLE);

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                n_addr    = r_addr + AW'(1);
                if (r_addr == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_cmd       = t_cmd'(i_command);
                    n_idx       = i_target_bit;
                    n_lim       = cur_lim;
                    n_addr      = '0;
                    n_base      = '0;
                    n_pend      = 1'b0;
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    if ((i_command == CMD_SET_BIT || i_command == CMD_CLEAR_BIT)
                        && CNT_W'(i_target_bit) >= cur_lim) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                issue      = r_base < BASE_W'(r_lim);
                n_pend     = issue;
                n_chk_addr = r_addr;
                n_chk_base = r_base;
                if (issue) begin
                    n_addr = r_addr + AW'(1);
                    n_base = r_base + WORD_STEP;
                end
                if (r_pend && is_find && ffs_hit) begin
                    n_res_found = 1'b1;
                    n_res_pos   = IDX_W'(r_chk_base + BASE_W'(ffs_k));
                    n_state     = ST_RESULT;
                end else if (r_pend && !is_find && sc_hit) begin
                    ram_we      = 1'b1;
                    ram_wdata   = (r_cmd == CMD_SET_BIT) ? (ram_rdata | bit_mask)
                                                         : (ram_rdata & ~bit_mask);
                    n_res_found = 1'b1;
                    n_res_pos   = r_idx;
                    n_state     = ST_RESULT;
                end else if (!issue) begin
                    // walked past the bound with no hit
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    n_state     = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_found  = r_res_found;
                    n_pos    = r_res_pos;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_ovalid    <= 1'b0;
            r_pend      <= 1'b0;
            r_addr      <= '0;
            r_bit_count <= CNT_W'(CNT_RESET);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_addr   <= n_addr;
            if (i_cfg_wr_en) begin
                r_bit_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_lim       <= n_lim;
        r_base      <= n_base;
        r_chk_addr  <= n_chk_addr;
        r_chk_base  <= n_chk_base;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_found     <= n_found;
        r_pos       <= n_pos;
    end

    assign o_out_valid = r_ovalid;
    assign o_found     = r_found;
    assign o_position  = r_pos;

    `BFFM_ASSERT_NOW(a_miss_pos_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_position == '0)
    `BFFM_ASSERT_NOW(a_no_out_in_clear, i_clk, i_rst_n, r_state == ST_CLR, !o_out_valid)
    `BFFM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `BFFM_ASSERT_NOW(a_hit_below_limit, i_clk, i_rst_n, $rose(o_out_valid) && o_found, CNT_W'(o_position) < r_lim)
    `BFFM_ASSERT_NOW(a_mark_echo, i_clk, i_rst_n, $rose(o_out_valid) && o_found && !is_find, o_position == r_idx)

endmodule

/* tb/sv/bitmap_find_first_and_mark_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bitmap_find_first_and_mark_unit_tb
// Drives find / set / clear words into the bitmap unit under several bit_count
// settings, keeps its own copy of the bitmap to predict each reply, and checks
// every reply in order while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module bitmap_find_first_and_mark_unit_tb;

    import bffm_pkg::*;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
    } t_stim_word;

    class bitmap_scoreboard;
        typedef struct {
            bit             found;
            bit [IDX_W-1:0] position;
        } t_reply;

        bit [MAX_BITS_DEF-1:0] occupancy;
        bit [CNT_W-1:0]        bound;
        t_reply                replies_due[$];
        int                    mismatches;

        function new();
            occupancy  = '0;
            bound      = CNT_W'(CNT_RESET);
            mismatches = 0;
        endfunction

        function void load_bound(bit [CNT_W-1:0] v);
            bound = v;
        endfunction

        // bound above capacity acts as capacity
        function int limit();
            return (int'(bound) > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(bound);
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function void note_command(t_cmd cmd, bit [IDX_W-1:0] idx);
            t_reply r;
            int     lim;
            int     i;
            bit     want;
            r.found    = 1'b0;
            r.position = '0;
            lim        = limit();
            if (cmd == CMD_FIND_SET || cmd == CMD_FIND_CLEAR) begin
                want = (cmd == CMD_FIND_SET);
                for (i = 0; i < lim; i++) begin
                    if (occupancy[i] == want) begin
                        r.found    = 1'b1;
                        r.position = IDX_W'(i);
                        break;
                    end
                end
            end else if (int'(idx) < lim) begin
                occupancy[idx] = (cmd == CMD_SET_BIT);
                r.found        = 1'b1;
                r.position     = idx;
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic found, logic [IDX_W-1:0] position);
            t_reply r;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: found=%0b position=%0d", found, position);
                return;
            end
            r = replies_due.pop_front();
            if (found !== r.found || position !== r.position) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                             r.found, r.position, found, position);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CNT_W-1:0] i_cfg_wr_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [1:0]       i_command;
    logic [IDX_W-1:0] i_target_bit;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_found;
    logic [IDX_W-1:0] o_position;

    bitmap_scoreboard sb;
    t_stim_word       stim_q[$];
    bit               hold_req;
    int               random_sent;

    bitmap_find_first_and_mark_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_target_bit  (i_target_bit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // accepted words on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_reply(o_found, o_position);
            if (i_in_valid && !o_in_stall)
                sb.note_command(t_cmd'(i_command), i_target_bit);
        end
    end

    // receiver: segments of differing stall density, plus one long hold-off on request
    initial begin : out_stall_gen
        int seg;
        int pct;
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            seg = $urandom_range(10, 60);
            pct = $urandom_range(0, 3) * 20;
            repeat (seg) begin
                if (hold_req) begin
                    hold_req  = 1'b0;
                    hold_left = 300;
                end
                if (hold_left > 0) begin
                    i_out_stall <= 1'b1;
                    hold_left--;
                end else begin
                    i_out_stall <= ($urandom_range(0, 99) < pct);
                end
                @(posedge i_clk);
            end
        end
    end

    task automatic push_word(t_cmd cmd, int idx);
        t_stim_word w;
        w.cmd = cmd;
        w.idx = IDX_W'(idx);
        stim_q.push_back(w);
    endtask

    task automatic send_words(bit with_gaps);
        t_stim_word w;
        int         burst;
        int         gap;
        gap = 0;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && stim_q.size() > 0) begin
                w = stim_q.pop_front();
                i_in_valid   <= 1'b1;
                i_command    <= w.cmd;
                i_target_bit <= w.idx;
                @(posedge i_clk);
                while (o_in_stall) @(posedge i_clk);
                burst--;
            end
            gap = (with_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (gap == 0)
            i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bound(bit [CNT_W-1:0] v);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.load_bound(v);
    endtask

    function automatic bit [CNT_W-1:0] pick_bound();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CNT_W'(CNT_MAX);
            2:       return CNT_W'(CNT_RESET);
            3:       return CNT_W'($urandom_range(MAX_BITS_DEF + 1, CNT_MAX - 1));
            4:       return CNT_W'($urandom_range(32, 33));
            5:       return CNT_W'($urandom_range(1, CNT_MAX));
            default: return CNT_W'($urandom_range(1, 64));
        endcase
    endfunction

    // one random item, or a run of consecutive sets / clears followed by both finds
    task automatic build_batch(int lim);
        int   r;
        int   start;
        int   len;
        int   j;
        int   idx;
        t_cmd op;
        r = $urandom_range(0, 9);
        if (r < 2 && lim > 0) begin
            start = $urandom_range(0, 1) ? 0 : $urandom_range(0, lim - 1);
            len   = $urandom_range(4, 40);
            op    = ($urandom_range(0, 3) == 0) ? CMD_CLEAR_BIT : CMD_SET_BIT;
            for (j = 0; j < len && start + j < MAX_BITS_DEF; j++)
                push_word(op, start + j);
            push_word(CMD_FIND_CLEAR, $urandom_range(0, MAX_BITS_DEF - 1));
            push_word(CMD_FIND_SET, $urandom_range(0, MAX_BITS_DEF - 1));
        end else begin
            if (r == 2 && lim > 0)
                idx = (lim < MAX_BITS_DEF && $urandom_range(0, 1)) ? lim : lim - 1;
            else if (lim > 0 && $urandom_range(0, 4) != 0)
                idx = $urandom_range(0, lim - 1);
            else
                idx = $urandom_range(0, MAX_BITS_DEF - 1);
            push_word(t_cmd'($urandom_range(0, 3)), idx);
        end
    endtask

    initial begin : main
        int phase;
        int n;
        int lim;
        sb            = new();
        hold_req      = 1'b0;
        random_sent   = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_FIND_SET;
        i_target_bit  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty map at the reset bound, then a few marks at word edges
        push_word(CMD_FIND_SET, 0);
        push_word(CMD_FIND_CLEAR, 0);
        push_word(CMD_SET_BIT, 0);
        push_word(CMD_SET_BIT, 1023);
        push_word(CMD_SET_BIT, 31);
        push_word(CMD_SET_BIT, 32);
        push_word(CMD_FIND_SET, 0);
        push_word(CMD_CLEAR_BIT, 0);
        push_word(CMD_FIND_SET, 1023);
        push_word(CMD_FIND_CLEAR, 0);
        push_word(CMD_CLEAR_BIT, 5);
        send_words(1'b0);

        // zero bound: nothing in use, everything rejected
        write_bound('0);
        push_word(CMD_FIND_SET, 0);
        push_word(CMD_FIND_CLEAR, 0);
        push_word(CMD_SET_BIT, 0);
        push_word(CMD_CLEAR_BIT, 1023);
        send_words(1'b0);

        // bound above capacity: top bit still reachable
        write_bound(CNT_W'(CNT_MAX));
        push_word(CMD_CLEAR_BIT, 31);
        push_word(CMD_CLEAR_BIT, 32);
        push_word(CMD_FIND_SET, 0);
        push_word(CMD_FIND_CLEAR, 0);
        send_words(1'b0);

        // single bit in use: full map, index just past the bound
        write_bound(CNT_W'(1));
        push_word(CMD_FIND_CLEAR, 0);
        push_word(CMD_SET_BIT, 0);
        push_word(CMD_FIND_CLEAR, 0);
        push_word(CMD_SET_BIT, 1);
        push_word(CMD_FIND_SET, 0);
        send_words(1'b0);

        phase = 0;
        while (random_sent < 700) begin
            write_bound(phase == 0 ? CNT_W'(CNT_RESET) : pick_bound());
            lim = sb.limit();
            n   = (lim == 0) ? 10 : $urandom_range(30, 80);
            while (stim_q.size() < n)
                build_batch(lim);
            random_sent += stim_q.size();
            if (phase == 2) begin
                // long output hold-off while input keeps offering
                hold_req = 1'b1;
                send_words(1'b0);
            end else begin
                send_words(1'b1);
            end
            phase++;
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
